@@ src/lbdc_pkg.sv @@
// Package for the LCD bus decimal capture block: widths, byte classes,
// register indexes and the queue entry type. Depends on nothing.
`default_nettype none
package lbdc_pkg;

  localparam int unsigned NibbleW    = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MantW      = 32;
  localparam int unsigned FracW      = 4;
  localparam int unsigned CharW      = 6;
  localparam int unsigned MaxChars   = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0]   StartCodeRst = 8'h80;
  localparam logic [ByteW-1:0]   EndCodeRst   = 8'hC0;
  localparam logic [ByteW-1:0]   CharPoint    = 8'h2E;
  localparam logic [ByteW-1:0]   CharZero     = 8'h30;
  localparam logic [ByteW-1:0]   CharNine     = 8'h39;
  localparam logic [FracW-1:0]   FracMax      = '1;
  localparam logic [MantW-1:0]   MantMax      = '1;
  localparam logic [CharW-1:0]   CharLimit    = CharW'(MaxChars);

  localparam logic [CfgIdxW-1:0] RegStartCode = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEndCode   = 1'd1;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_END,
    KIND_POINT,
    KIND_DIGIT,
    KIND_OTHER
  } byte_kind_e;

  typedef struct packed {
    byte_kind_e         kind;
    logic [NibbleW-1:0] digit;
  } q_entry_t;

endpackage
`default_nettype wire

@@ src/lbdc_in_if.sv @@
// Nibble input channel: valid/ready handshake with one 4-bit bus sample.
// Uses lbdc_pkg for the width.
`default_nettype none
interface lbdc_in_if;
  import lbdc_pkg::*;
  logic               valid;
  logic               ready;
  logic [NibbleW-1:0] nibble;
  modport source (output valid, output nibble, input ready);
  modport sink   (input valid, input nibble, output ready);
endinterface
`default_nettype wire

@@ src/lbdc_out_if.sv @@
// Result channel: valid/ready handshake with the captured number fields.
// Uses lbdc_pkg for the widths.
`default_nettype none
interface lbdc_out_if;
  import lbdc_pkg::*;
  logic             valid;
  logic             ready;
  logic [MantW-1:0] mantissa;
  logic [FracW-1:0] fraction_digits;
  logic             saturated;
  logic [CharW-1:0] char_count;
  modport source (output valid, output mantissa, output fraction_digits,
                  output saturated, output char_count, input ready);
  modport sink   (input valid, input mantissa, input fraction_digits,
                  input saturated, input char_count, output ready);
endinterface
`default_nettype wire

@@ src/lbdc_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Uses lbdc_pkg for the widths.
`default_nettype none
interface lbdc_cfg_if;
  import lbdc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/lcd_bus_decimal_capture.sv @@
// Top level of the LCD bus decimal capture block: front end, byte queue
// and back end. Depends on lbdc_pkg, the channel interfaces and submodules.
//
// Usage:
//   in_i carries one nibble (DB7..DB4) per beat, high nibble first, then low.
//   Each pair forms a byte. The start-code byte clears and arms capture;
//   armed bytes are decimal text (digits, one point, others ignored). The
//   end-code byte sends one beat on out_o: mantissa, fraction digit count,
//   saturation flag and character count; capture is then cleared and disarmed.
//   cfg_i writes start_code (index 0) or end_code (index 1) and is always ready;
//   write it only while the block is idle; the block does not enforce this.
// Timing:
//   One nibble per cycle while in_i.ready is high. The end code's low-nibble
//   beat is first written into the classified-byte queue; the back end
//   then pops it and loads the result register, which drives out_o.
//   Those two register stages lie between in_i and out_o.
// Reset (rst_ni low, asynchronous): codes return to 0x80 / 0xC0, the block
//   expects a high nibble, capture is disarmed and all counts are zero.
// Stall: while out_o is not taken, the result holds; the back end keeps
//   processing bytes until the next end code, and the two-entry queue then
//   fills and drops in_i.ready on low-nibble beats.
`default_nettype none
module lcd_bus_decimal_capture (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbdc_in_if.sink    in_i,
  lbdc_cfg_if.sink   cfg_i,
  lbdc_out_if.source out_o
);
  import lbdc_pkg::*;

  logic     push_valid, push_ready;
  q_entry_t push_entry;
  logic     pop_valid, pop;
  q_entry_t pop_entry;

  // pair nibbles and classify bytes
  lbdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // decouple classification from capture
  lbdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  // accumulate digits and emit on end code
  lbdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

@@ src/lbdc_front.sv @@
// Front end: pairs nibbles into bytes, holds the code registers and
// classifies each byte for the back end. Depends on lbdc_pkg and the channels.
`default_nettype none
module lbdc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lbdc_in_if.sink             in_i,
  lbdc_cfg_if.sink            cfg_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lbdc_pkg::q_entry_t  push_entry_o
);
  import lbdc_pkg::*;

  logic               low_phase_q, low_phase_d;
  logic [NibbleW-1:0] high_nibble_q, high_nibble_d;
  logic [ByteW-1:0]   start_code_q, start_code_d;
  logic [ByteW-1:0]   end_code_q, end_code_d;
  logic [ByteW-1:0]   byte_w;
  logic               in_fire;

  assign in_i.ready   = !low_phase_q || push_ready_i;
  assign in_fire      = in_i.valid && in_i.ready;
  assign push_valid_o = in_i.valid && low_phase_q;
  assign byte_w       = {high_nibble_q, in_i.nibble};
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    push_entry_o.digit = byte_w[NibbleW-1:0];
    if (byte_w == start_code_q) begin
      push_entry_o.kind = KIND_START;
    end else if (byte_w == end_code_q) begin
      push_entry_o.kind = KIND_END;
    end else if (byte_w == CharPoint) begin
      push_entry_o.kind = KIND_POINT;
    end else if (byte_w >= CharZero && byte_w <= CharNine) begin
      push_entry_o.kind = KIND_DIGIT;
    end else begin
      push_entry_o.kind = KIND_OTHER;
    end
  end

  always_comb begin
    low_phase_d   = low_phase_q;
    high_nibble_d = high_nibble_q;
    if (in_fire) begin
      low_phase_d = !low_phase_q;
      if (!low_phase_q) begin
        high_nibble_d = in_i.nibble;
      end
    end
  end

  always_comb begin
    start_code_d = start_code_q;
    end_code_d   = end_code_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegStartCode: start_code_d = cfg_i.data;
        RegEndCode:   end_code_d   = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_phase_q   <= 1'b0;
      high_nibble_q <= '0;
      start_code_q  <= StartCodeRst;
      end_code_q    <= EndCodeRst;
    end else begin
      low_phase_q   <= low_phase_d;
      high_nibble_q <= high_nibble_d;
      start_code_q  <= start_code_d;
      end_code_q    <= end_code_d;
    end
  end

endmodule
`default_nettype wire

@@ src/lbdc_queue.sv @@
// Short register queue of classified bytes between front and back end.
// Depends on lbdc_pkg.
`default_nettype none
module lbdc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  lbdc_pkg::q_entry_t push_entry_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output lbdc_pkg::q_entry_t pop_entry_o
);
  import lbdc_pkg::*;

  q_entry_t         slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != QCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ src/lbdc_back.sv @@
// Back end: runs the capture state on classified bytes and holds the
// result register. Depends on lbdc_pkg and the result channel.
`default_nettype none
module lbdc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_o,
  input  lbdc_pkg::q_entry_t pop_entry_i,
  lbdc_out_if.source         out_o
);
  import lbdc_pkg::*;

  logic             armed_q, armed_d;
  logic             in_frac_q, in_frac_d;
  logic [MantW-1:0] acc_q, acc_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [CharW-1:0] chars_q, chars_d;
  logic             ovf_q, ovf_d;

  logic             out_valid_q, out_valid_d;
  logic [MantW-1:0] out_mant_q;
  logic [FracW-1:0] out_frac_q;
  logic             out_sat_q;
  logic [CharW-1:0] out_chars_q;

  logic             out_free, is_end, load_out, at_limit;
  logic [MantW+3:0] acc_next;

  assign out_free = !out_valid_q || out_o.ready;
  assign is_end   = pop_entry_i.kind == KIND_END;
  assign pop_o    = pop_valid_i && (!is_end || out_free);
  assign load_out = pop_o && is_end;
  assign at_limit = chars_q >= CharLimit;

  // acc * 10 + digit as two shifts and two adds
  assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                  + {(MantW)'(0), pop_entry_i.digit};

  always_comb begin
    armed_d   = armed_q;
    in_frac_d = in_frac_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    chars_d   = chars_q;
    ovf_d     = ovf_q;
    if (pop_o) begin
      case (pop_entry_i.kind) inside
        KIND_START, KIND_END: begin
          armed_d   = pop_entry_i.kind == KIND_START;
          in_frac_d = 1'b0;
          acc_d     = '0;
          frac_d    = '0;
          chars_d   = '0;
          ovf_d     = 1'b0;
        end
        default: begin
          if (armed_q) begin
            if (at_limit) begin
              ovf_d = 1'b1;
            end else begin
              chars_d = chars_q + 1'b1;
              if (pop_entry_i.kind == KIND_POINT) begin
                in_frac_d = 1'b1;
              end else if (pop_entry_i.kind == KIND_DIGIT) begin
                if (acc_next[MantW+3:MantW] != '0) begin
                  acc_d = MantMax;
                  ovf_d = 1'b1;
                end else begin
                  acc_d = acc_next[MantW-1:0];
                end
                if (in_frac_q) begin
                  if (frac_q == FracMax) begin
                    ovf_d = 1'b1;
                  end else begin
                    frac_d = frac_q + 1'b1;
                  end
                end
              end
            end
          end
        end
      endcase
    end
  end

  assign out_valid_d = load_out || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_mant_q  <= acc_q;
      out_frac_q  <= frac_q;
      out_sat_q   <= ovf_q;
      out_chars_q <= chars_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      in_frac_q   <= 1'b0;
      acc_q       <= '0;
      frac_q      <= '0;
      chars_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      in_frac_q   <= in_frac_d;
      acc_q       <= acc_d;
      frac_q      <= frac_d;
      chars_q     <= chars_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.mantissa        = out_mant_q;
  assign out_o.fraction_digits = out_frac_q;
  assign out_o.saturated       = out_sat_q;
  assign out_o.char_count      = out_chars_q;

endmodule
`default_nettype wire

@@ tb/tb_lcd_bus_decimal_capture.sv @@
// Self-checking testbench for lcd_bus_decimal_capture: nibble stream in,
// captured decimal numbers out, checked against an in-bench behavioral model.
// Depends on lbdc_pkg, the three channel interfaces and the block itself.
`timescale 1ns / 1ps
module tb_lcd_bus_decimal_capture;
  import lbdc_pkg::*;

  // One expected beat on the result channel.
  typedef struct packed {
    logic [MantW-1:0] mantissa;
    logic [FracW-1:0] frac_digits;
    logic             saturated;
    logic [CharW-1:0] char_count;
  } number_t;

  localparam int unsigned NibbleTarget = 1150;
  localparam int unsigned QuietTail    = 150;
  localparam int unsigned DrainCap     = 4000;
  localparam int unsigned SettleCycles = 4;

  logic clk_i = 1'b0;
  logic rst_ni;

  lbdc_in_if  in_ch ();
  lbdc_out_if out_ch ();
  lbdc_cfg_if cfg_ch ();

  lcd_bus_decimal_capture DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  // 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Capture model: its own copy of the codes and the capture state.
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0]   start_code_q  = StartCodeRst;
  logic [ByteW-1:0]   end_code_q    = EndCodeRst;
  logic               expect_low    = 1'b0;
  logic [NibbleW-1:0] held_high     = '0;
  logic               capturing     = 1'b0;
  logic               after_point   = 1'b0;
  logic [MantW-1:0]   mantissa_acc  = '0;
  logic [FracW-1:0]   frac_seen     = '0;
  logic [CharW-1:0]   chars_kept    = '0;
  logic               overflow_seen = 1'b0;

  number_t pending_numbers[$];

  int unsigned errors       = 0;
  int unsigned nibbles_sent = 0;
  int unsigned gap_pct      = 20;   // chance of an idle burst before a nibble
  int unsigned stall_pct    = 15;   // chance of a stall burst on the result side
  int unsigned stall_left   = 0;
  bit          quiet_tail   = 1'b0; // no idling on either side

  function automatic void clear_capture();
    after_point   = 1'b0;
    mantissa_acc  = '0;
    frac_seen     = '0;
    chars_kept    = '0;
    overflow_seen = 1'b0;
  endfunction

  // Fold one armed character into the running number.
  function automatic void absorb_char(logic [ByteW-1:0] ch);
    logic [MantW+3:0] grown;
    if (chars_kept >= CharLimit) begin
      // Bound reached: drop the character, flag it.
      overflow_seen = 1'b1;
      return;
    end
    chars_kept = chars_kept + 1'b1;
    if (ch == CharPoint) begin
      after_point = 1'b1;
      return;
    end
    if (ch >= CharZero && ch <= CharNine) begin
      // Digits 0x30..0x39 carry their value in the low nibble.
      grown = {4'd0, mantissa_acc} * 36'd10 + {32'd0, ch[3:0]};
      if (grown > {4'd0, MantMax}) begin
        mantissa_acc  = MantMax;
        overflow_seen = 1'b1;
      end else begin
        mantissa_acc = grown[MantW-1:0];
      end
      if (after_point) begin
        if (frac_seen == FracMax) overflow_seen = 1'b1;
        else frac_seen = frac_seen + 1'b1;
      end
    end
  endfunction

  // Advance the model by one accepted nibble; queue a number on an end code.
  function automatic void track_nibble(logic [NibbleW-1:0] n);
    logic [ByteW-1:0] code;
    if (!expect_low) begin
      held_high  = n;
      expect_low = 1'b1;
      return;
    end
    expect_low = 1'b0;
    code = {held_high, n};
    // Start wins when both codes match the same byte.
    if (code == start_code_q) begin
      clear_capture();
      capturing = 1'b1;
    end else if (code == end_code_q) begin
      pending_numbers.push_back(number_t'{mantissa_acc, frac_seen, overflow_seen,
                                          chars_kept});
      capturing = 1'b0;
      clear_capture();
    end else if (capturing) begin
      absorb_char(code);
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on ready, none in the quiet tail.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (quiet_tail) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result beat against the oldest expected number.
  always @(posedge clk_i) begin
    number_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_numbers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result mantissa %0d", out_ch.mantissa));
      end else begin
        want = pending_numbers.pop_front();
        if (out_ch.mantissa !== want.mantissa)
          flag_mismatch($sformatf("mantissa got %0d want %0d",
                                  out_ch.mantissa, want.mantissa));
        if (out_ch.fraction_digits !== want.frac_digits)
          flag_mismatch($sformatf("fraction_digits got %0d want %0d",
                                  out_ch.fraction_digits, want.frac_digits));
        if (out_ch.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated got %0b want %0b",
                                  out_ch.saturated, want.saturated));
        if (out_ch.char_count !== want.char_count)
          flag_mismatch($sformatf("char_count got %0d want %0d",
                                  out_ch.char_count, want.char_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered just after a rising edge and returns just
  // after one; valid stays high between back-to-back beats.
  // ---------------------------------------------------------------------------
  task automatic send_nibble(input logic [NibbleW-1:0] n);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.nibble <= n;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    track_nibble(n);
    nibbles_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    send_nibble(b[7:4]);
    send_nibble(b[3:0]);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid, wait for every expected number, then let the pipe settle so
  // that no byte is still in flight when a code changes.
  task automatic drain_block();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_numbers.size() != 0 && waited < DrainCap) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_code(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == RegStartCode) start_code_q = value;
    else end_code_q = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_codes(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e);
    drain_block();
    write_code(RegStartCode, s);
    write_code(RegEndCode, e);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // End while disarmed, second point, zero byte, all-ones byte, restart.
  task automatic test_directed_text();
    send_byte(EndCodeRst);
    send_byte(StartCodeRst);
    send_text("4.2.7");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(EndCodeRst);
    send_byte(StartCodeRst);
    send_text("5");
    send_byte(StartCodeRst);
    send_text("3");
    send_byte(EndCodeRst);
  endtask

  // Largest mantissa, one past it, and digits after saturation.
  task automatic test_mantissa_limit();
    send_byte(start_code_q);
    send_text("4294967295");
    send_byte(end_code_q);
    send_byte(start_code_q);
    send_text("4294967296");
    send_byte(end_code_q);
    send_byte(start_code_q);
    send_text("99999999999.12");
    send_byte(end_code_q);
  endtask

  // Exactly at the character bound, then one character past it.
  task automatic test_char_bound();
    for (int extra = 0; extra < 2; extra++) begin
      send_byte(start_code_q);
      repeat (MaxChars - 1) send_text("z");
      send_text("4");
      if (extra != 0) send_text("5");
      send_byte(end_code_q);
    end
  endtask

  // More fraction digits than the count can hold.
  task automatic test_fraction_limit();
    send_byte(start_code_q);
    send_text(".");
    repeat (16) send_text("0");
    send_byte(end_code_q);
  endtask

  // Extreme code values, equal codes, and a stray nibble shifting the phase.
  task automatic test_code_extremes();
    set_codes(8'h00, 8'hFF);
    send_byte(8'h00);
    send_text("12");
    send_byte(8'hFF);
    set_codes(8'hFF, 8'h00);
    send_byte(8'hFF);
    send_text("7.5");
    send_byte(8'h00);
    set_codes(8'h5A, 8'h5A);
    send_byte(8'h5A);
    send_text("3");
    send_byte(8'h5A);
    set_codes(8'h5A, 8'h21);
    send_text("8!");
    send_nibble(4'h3);     // stray: splits bytes until the next stray
    send_text("!6");
    send_nibble(4'hC);
    send_byte(8'h21);
    set_codes(StartCodeRst, EndCodeRst);
  endtask

  // One framed number with random content, sometimes preceded by noise or
  // left without its end code.
  task automatic send_random_frame();
    int unsigned len;
    int unsigned pick;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 4) send_nibble(4'($urandom_range(0, 15)));
    send_byte(start_code_q);
    pick = $urandom_range(0, 99);
    if (pick < 85) len = $urandom_range(0, 10);
    else if (pick < 95) len = $urandom_range(11, 14);
    else len = $urandom_range(30, 40);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) send_byte(CharZero + 8'($urandom_range(0, 9)));
      else if (pick < 75) send_byte(CharPoint);
      else send_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) >= 5) send_byte(end_code_q);
  endtask

  // Phases of random frames, each with its own codes and idling mix.
  task automatic test_random_frames();
    logic [ByteW-1:0] s;
    logic [ByteW-1:0] e;
    while (nibbles_sent < NibbleTarget - QuietTail) begin
      case ($urandom_range(0, 6))
        0: set_codes(8'h00, 8'hFF);
        1: set_codes(8'hFF, 8'h00);
        2: set_codes(StartCodeRst, EndCodeRst);
        3: begin
          s = 8'($urandom_range(0, 255));
          set_codes(s, s);
        end
        4: begin
          s = 8'($urandom_range(0, 255));
          e = 8'($urandom_range(0, 255));
          set_codes(s, e);
        end
        default: begin
          s = 8'($urandom_range(128, 255));
          e = 8'($urandom_range(128, 255));
          set_codes(s, e);
        end
      endcase
      gap_pct   = $urandom_range(0, 2) * 20;
      stall_pct = $urandom_range(0, 2) * 15;
      repeat (6) send_random_frame();
    end
  endtask

  // Back-to-back beats on both sides to the end of the stimulus.
  task automatic test_quiet_tail();
    set_codes(StartCodeRst, EndCodeRst);
    quiet_tail = 1'b1;
    while (nibbles_sent < NibbleTarget) send_random_frame();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.nibble <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= RegStartCode;
    cfg_ch.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_text();
    test_mantissa_limit();
    test_char_bound();
    test_fraction_limit();
    test_code_extremes();
    test_random_frames();
    test_quiet_tail();

    drain_block();
    repeat (10) @(posedge clk_i);
    if (pending_numbers.size() != 0)
      flag_mismatch($sformatf("%0d expected numbers never arrived",
                              pending_numbers.size()));
    if (errors == 0) begin
      $display("[lcd_bus_decimal_capture] OK");
    end else begin
      $display("[lcd_bus_decimal_capture] ERROR");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[lcd_bus_decimal_capture] ERROR");
    $finish;
  end

endmodule
